// ===== rtl/core/ppq_pkg.sv =====
package ppq_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam int COORD_W = 32;     // Q16.16 coordinate
    localparam int DIST_W  = 32;     // Q16.16 distance / curvature
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int DEN_W   = 3 * MAG_W;
    localparam int D2_W    = 64;
    localparam int NEAR_W  = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PREVIEW   = CFG_IDX_W'(1);

    localparam logic [DIST_W-1:0] LOOKAHEAD_RESET = DIST_W'(327680);
    localparam logic [DIST_W-1:0] PREVIEW_RESET   = DIST_W'(655360);

    // 1e-9 m^3 in raw Q48.48
    localparam logic [DEN_W-1:0] DEGEN_LIMIT = DEN_W'(281475);

    function automatic logic signed [DIFF_W-1:0] sext(input logic [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] n;
        n = -v;
        return v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
    endfunction

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] acc,
                                                  input logic [MAG_W-1:0] d);
        logic [DIST_W+1:0] s;
        s = {2'b00, acc} + {1'b0, d};
        return (s[DIST_W+1:DIST_W] != 2'b00) ? '1 : s[DIST_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ppq_if.sv =====
interface ppq_point_if import ppq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface ppq_result_if import ppq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      target_valid;
    logic [NEAR_W-1:0]         nearest_index;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic [DIST_W-1:0]         lookahead_used;
    logic [DIST_W-1:0]         remaining_length;
    logic [DIST_W-1:0]         max_curvature;
    logic                      points_dropped;

    modport source (output valid, target_valid, nearest_index, target_x, target_y,
                    lookahead_used, remaining_length, max_curvature, points_dropped,
                    input ready);
    modport sink   (input valid, target_valid, nearest_index, target_x, target_y,
                    lookahead_used, remaining_length, max_curvature, points_dropped,
                    output ready);
endinterface

// ===== rtl/core/ppq_store.sv =====
module ppq_store
    import ppq_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEF
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [COORD_W-1:0]       wr_x,
    input  logic [COORD_W-1:0]       wr_y,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [COORD_W-1:0]       rd_x,
    output logic [COORD_W-1:0]       rd_y
);

    logic [COORD_W-1:0] mem_x [DEPTH];
    logic [COORD_W-1:0] mem_y [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end

endmodule

// ===== rtl/core/ppq_sqrt.sv =====
module ppq_sqrt
    import ppq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   radicand,
    output logic                done,
    output logic [MAG_W-1:0]    root
);

    localparam int REM_W  = MAG_W + 3;
    localparam int STEP_W = $clog2(MAG_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [PROD_W-1:0] v_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  root_reg;

    logic [REM_W+1:0]  rsh;
    logic [REM_W+1:0]  trial;
    logic              take;

    // one root bit per cycle, two radicand bits shifted in
    assign rsh   = {rem_reg, v_reg[PROD_W-1 -: 2]};
    assign trial = (REM_W + 2)'({root_reg, 2'b01});
    assign take  = (rsh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[PROD_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= REM_W'(rsh - trial);
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rsh);
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/ppq_div.sv =====
module ppq_div
    import ppq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   mag,
    input  logic [DEN_W-1:0]    den,
    output logic                done,
    output logic [DIST_W-1:0]   quo
);

    // quotient of (mag << 33) / den, saturated to DIST_W bits
    localparam int STEP_W = $clog2(DIST_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DIST_W-1:0] quo_reg;

    logic [DEN_W-1:0]  rem_init;
    logic              sat;
    logic [DEN_W:0]    sh;
    logic              take;

    assign rem_init = DEN_W'({mag, 1'b0});
    assign sat      = (rem_init >= den);
    assign sh       = {rem_reg, 1'b0};
    assign take     = (sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !sat;
                done_reg <= sat;
                cnt_reg  <= STEP_W'(DIST_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= rem_init;
            quo_reg <= sat ? '1 : '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= DEN_W'(sh - {1'b0, den_reg});
                quo_reg <= {quo_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= DEN_W'(sh);
                quo_reg <= {quo_reg[DIST_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/pursuit_path_query_engine.sv =====
// Pure pursuit path query engine. Path points (signed Q16.16 metres, vehicle frame) arrive one
// per transfer on the point channel; the x^2 and y^2 products share the one 33x33 multiplier
// before the nearest-point compare. The transfer with last_point set starts the query pass,
// during which point.ready is low. The pass walks the point store once from the nearest point
// to the end, one segment at a time: read, two squares and a square root, plus, for every
// segment after the first inside the preview window, chord length, triple product for the
// degeneracy test and, unless the triple is near-flat, cross product and a divide; then the
// distance to the target. The square root and the divider each produce one bit per cycle and
// set the length of the pass. The result sits in an output register until taken; point
// loading for the next path may proceed meanwhile. Configuration (lookahead, preview distance)
// is written via cfg_wr_en/cfg_index/cfg_data; the user must write it while the block is idle,
// as the block does not enforce it. Unknown indexes are ignored. No clearing pass after reset.
module pursuit_path_query_engine
    import ppq_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ppq_point_if.sink             point,
    ppq_result_if.source          result
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CMP_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    // sequencer codes
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_L_SQX    = 5'd1;
    localparam logic [4:0] S_L_SQY    = 5'd2;
    localparam logic [4:0] S_L_CMP    = 5'd3;
    localparam logic [4:0] S_C_START  = 5'd4;
    localparam logic [4:0] S_C_GETCUR = 5'd5;
    localparam logic [4:0] S_C_RDNXT  = 5'd6;
    localparam logic [4:0] S_C_GETNXT = 5'd7;
    localparam logic [4:0] S_N_SQA    = 5'd8;
    localparam logic [4:0] S_N_SQB    = 5'd9;
    localparam logic [4:0] S_N_SUM    = 5'd10;
    localparam logic [4:0] S_N_WAIT   = 5'd11;
    localparam logic [4:0] S_C_SEG    = 5'd12;
    localparam logic [4:0] S_C_AC     = 5'd13;
    localparam logic [4:0] S_D_M1     = 5'd14;
    localparam logic [4:0] S_D_M2     = 5'd15;
    localparam logic [4:0] S_D_M3     = 5'd16;
    localparam logic [4:0] S_D_M4     = 5'd17;
    localparam logic [4:0] S_X_M1     = 5'd18;
    localparam logic [4:0] S_X_M2     = 5'd19;
    localparam logic [4:0] S_X_M3     = 5'd20;
    localparam logic [4:0] S_X_WAIT   = 5'd21;
    localparam logic [4:0] S_C_ADV    = 5'd22;
    localparam logic [4:0] S_C_FINAL  = 5'd23;
    localparam logic [4:0] S_C_LD     = 5'd24;
    localparam logic [4:0] S_OUT      = 5'd25;

    logic [4:0]                state_reg;
    logic [4:0]                ret_reg;

    // configuration
    logic [DIST_W-1:0]         la_reg;
    logic [DIST_W-1:0]         pv_reg;

    // path state
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          near_reg;
    logic [D2_W-1:0]           near_d2_reg;
    logic                      ovf_reg;
    logic                      last_reg;
    logic                      room_reg;

    // shared multiplier
    logic [MAG_W-1:0]          mul_a;
    logic [MAG_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic [PROD_W-1:0]         mul_q_reg;
    logic [PROD_W-1:0]         tmp_reg;
    logic [MAG_W-1:0]          ua_reg;
    logic [MAG_W-1:0]          ub_reg;

    // point store
    logic                      st_wr_en;
    logic [IDX_W-1:0]          st_rd_addr;
    logic [COORD_W-1:0]        st_rd_x;
    logic [COORD_W-1:0]        st_rd_y;

    // walk state
    logic [IDX_W-1:0]          j_reg;
    logic [COORD_W-1:0]        cx_reg;
    logic [COORD_W-1:0]        cy_reg;
    logic [COORD_W-1:0]        nx_reg;
    logic [COORD_W-1:0]        ny_reg;
    logic [COORD_W-1:0]        px_reg;
    logic [COORD_W-1:0]        py_reg;
    logic [COORD_W-1:0]        tx_reg;
    logic [COORD_W-1:0]        ty_reg;
    logic signed [DIFF_W-1:0]  abx_reg;
    logic signed [DIFF_W-1:0]  aby_reg;
    logic signed [DIFF_W-1:0]  bcx_reg;
    logic signed [DIFF_W-1:0]  bcy_reg;
    logic [MAG_W-1:0]          d_ab_reg;
    logic [MAG_W-1:0]          d_bc_reg;
    logic [MAG_W-1:0]          ac_reg;
    logic [DIST_W-1:0]         acc_t_reg;
    logic [DIST_W-1:0]         rem_len_reg;
    logic [DIST_W-1:0]         acc_p_reg;
    logic                      found_reg;
    logic                      pv_on_reg;
    logic [MAG_W-1:0]          t_hi_reg;
    logic [PROD_W-1:0]         lp_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [PROD_W-1:0]         p_reg;
    logic [DIST_W-1:0]         kmax_reg;
    logic [DIST_W-1:0]         ld_reg;
    logic                      tv_reg;

    // iterative units
    logic                      sq_start;
    logic [PROD_W-1:0]         sq_rad;
    logic                      sq_done;
    logic [MAG_W-1:0]          sq_root;
    logic                      dv_start;
    logic [PROD_W-1:0]         dv_mag;
    logic                      dv_done;
    logic [DIST_W-1:0]         dv_quo;

    // result register
    logic                      res_valid_reg;
    logic                      r_tv_reg;
    logic [NEAR_W-1:0]         r_near_reg;
    logic [COORD_W-1:0]        r_tx_reg;
    logic [COORD_W-1:0]        r_ty_reg;
    logic [DIST_W-1:0]         r_ld_reg;
    logic [DIST_W-1:0]         r_rem_reg;
    logic [DIST_W-1:0]         r_kmax_reg;
    logic                      r_drop_reg;

    // combinational helpers
    logic                      in_xfer;
    logic                      out_load;
    logic [PROD_W-1:0]         d2_sum;
    logic [DIST_W-1:0]         acc_t_sum;
    logic [DIST_W-1:0]         acc_p_sum;
    logic                      triple;
    logic [DEN_W-1:0]          den_c;
    logic                      s1;
    logic                      s2;
    logic signed [PROD_W+1:0]  t1;
    logic signed [PROD_W+1:0]  t2;
    logic signed [PROD_W+1:0]  xprod;
    logic [PROD_W+1:0]         cross_neg;
    logic [COORD_W-1:0]        sel_x;
    logic [COORD_W-1:0]        sel_y;

    assign point.ready = (state_reg == S_IDLE);
    assign in_xfer     = point.valid && point.ready;
    assign out_load    = (state_reg == S_OUT) && (!res_valid_reg || result.ready);
    assign st_wr_en    = in_xfer && (count_reg < CNT_MAX);

    assign d2_sum      = tmp_reg + mul_q_reg;
    assign acc_t_sum   = sat_add(acc_t_reg, sq_root);
    assign acc_p_sum   = sat_add(acc_p_reg, sq_root);
    // a triple ending at the current segment lies in the window
    assign triple      = pv_on_reg && (j_reg != near_reg);
    assign den_c       = DEN_W'(lp_reg) + {mul_q_reg, {MAG_W{1'b0}}};

    // cross = abx*bcy - aby*bcx from magnitudes and signs
    assign s1        = abx_reg[DIFF_W-1] ^ bcy_reg[DIFF_W-1];
    assign s2        = aby_reg[DIFF_W-1] ^ bcx_reg[DIFF_W-1];
    assign t1        = s1 ? -$signed({2'b00, p_reg}) : $signed({2'b00, p_reg});
    assign t2        = s2 ? -$signed({2'b00, mul_q_reg}) : $signed({2'b00, mul_q_reg});
    assign xprod     = t1 - t2;
    assign cross_neg = -xprod;
    assign dv_mag    = xprod[PROD_W+1] ? cross_neg[PROD_W-1:0] : xprod[PROD_W-1:0];

    assign sel_x = found_reg ? tx_reg : cx_reg;
    assign sel_y = found_reg ? ty_reg : cy_reg;

    assign sq_start = (state_reg == S_N_SUM);
    assign sq_rad   = d2_sum;
    assign dv_start = (state_reg == S_X_M3);

    assign st_rd_addr = (state_reg == S_C_START) ? near_reg
                                                 : IDX_W'({1'b0, j_reg} + 1'b1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg) inside
            S_L_SQX, S_N_SQA:
            begin
                mul_a = ua_reg;
                mul_b = ua_reg;
            end
            S_L_SQY, S_N_SQB:
            begin
                mul_a = ub_reg;
                mul_b = ub_reg;
            end
            S_D_M1:
            begin
                mul_a = d_ab_reg;
                mul_b = d_bc_reg;
            end
            S_D_M2:
            begin
                mul_a = mul_q_reg[MAG_W-1:0];
                mul_b = ac_reg;
            end
            S_D_M3:
            begin
                mul_a = t_hi_reg;
                mul_b = ac_reg;
            end
            S_X_M1:
            begin
                mul_a = abs_diff(abx_reg);
                mul_b = abs_diff(bcy_reg);
            end
            S_X_M2:
            begin
                mul_a = abs_diff(aby_reg);
                mul_b = abs_diff(bcx_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        mul_q_reg <= mul_p;
    end

    ppq_store #(
        .DEPTH   (MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_x    (point.point_x),
        .wr_y    (point.point_y),
        .rd_addr (st_rd_addr),
        .rd_x    (st_rd_x),
        .rd_y    (st_rd_y)
    );

    ppq_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    ppq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .mag   (dv_mag),
        .den   (den_reg),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg <= LOOKAHEAD_RESET;
            pv_reg <= PREVIEW_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_LOOKAHEAD)
            begin
                la_reg <= DIST_W'(cfg_data);
            end
            else if (cfg_index == CFG_PREVIEW)
            begin
                pv_reg <= DIST_W'(cfg_data);
            end
        end
    end

    // sequencer and path control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            count_reg     <= '0;
            near_reg      <= '0;
            near_d2_reg   <= '1;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            pv_on_reg     <= 1'b0;
            tv_reg        <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= S_L_SQX;
                    end
                end
                S_L_SQX:
                begin
                    state_reg <= S_L_SQY;
                end
                S_L_SQY:
                begin
                    state_reg <= S_L_CMP;
                end
                S_L_CMP:
                begin
                    if (room_reg)
                    begin
                        // first closest point wins
                        if (d2_sum < {2'b00, near_d2_reg})
                        begin
                            near_d2_reg <= d2_sum[D2_W-1:0];
                            near_reg    <= count_reg[IDX_W-1:0];
                        end
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    state_reg <= last_reg ? S_C_START : S_IDLE;
                end
                S_C_START:
                begin
                    found_reg <= 1'b0;
                    pv_on_reg <= (pv_reg != '0);
                    j_reg     <= near_reg;
                    if (count_reg < CNT_W'(2))
                    begin
                        tv_reg    <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        tv_reg    <= 1'b1;
                        state_reg <= S_C_GETCUR;
                    end
                end
                S_C_GETCUR:
                begin
                    if (CMP_W'(near_reg) + CMP_W'(1) < CMP_W'(count_reg))
                    begin
                        state_reg <= S_C_RDNXT;
                    end
                    else
                    begin
                        state_reg <= S_C_FINAL;
                    end
                end
                S_C_RDNXT:
                begin
                    state_reg <= S_C_GETNXT;
                end
                S_C_GETNXT:
                begin
                    ret_reg   <= S_C_SEG;
                    state_reg <= S_N_SQA;
                end
                S_N_SQA:
                begin
                    state_reg <= S_N_SQB;
                end
                S_N_SQB:
                begin
                    state_reg <= S_N_SUM;
                end
                S_N_SUM:
                begin
                    state_reg <= S_N_WAIT;
                end
                S_N_WAIT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                S_C_SEG:
                begin
                    if (!found_reg && (acc_t_sum >= la_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                    if (pv_on_reg)
                    begin
                        pv_on_reg <= (acc_p_sum < pv_reg);
                    end
                    if (triple)
                    begin
                        ret_reg   <= S_C_AC;
                        state_reg <= S_N_SQA;
                    end
                    else
                    begin
                        state_reg <= S_C_ADV;
                    end
                end
                S_C_AC:
                begin
                    state_reg <= S_D_M1;
                end
                S_D_M1:
                begin
                    state_reg <= S_D_M2;
                end
                S_D_M2:
                begin
                    state_reg <= S_D_M3;
                end
                S_D_M3:
                begin
                    state_reg <= S_D_M4;
                end
                S_D_M4:
                begin
                    // near-collinear or coincident triple is skipped
                    state_reg <= (den_c < DEGEN_LIMIT) ? S_C_ADV : S_X_M1;
                end
                S_X_M1:
                begin
                    state_reg <= S_X_M2;
                end
                S_X_M2:
                begin
                    state_reg <= S_X_M3;
                end
                S_X_M3:
                begin
                    state_reg <= S_X_WAIT;
                end
                S_X_WAIT:
                begin
                    if (dv_done)
                    begin
                        state_reg <= S_C_ADV;
                    end
                end
                S_C_ADV:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (CMP_W'(j_reg) + CMP_W'(2) < CMP_W'(count_reg))
                    begin
                        state_reg <= S_C_RDNXT;
                    end
                    else
                    begin
                        state_reg <= S_C_FINAL;
                    end
                end
                S_C_FINAL:
                begin
                    ret_reg   <= S_C_LD;
                    state_reg <= S_N_SQA;
                end
                S_C_LD:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        count_reg   <= '0;
                        near_reg    <= '0;
                        near_d2_reg <= '1;
                        ovf_reg     <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    ua_reg   <= abs_diff(sext(point.point_x));
                    ub_reg   <= abs_diff(sext(point.point_y));
                    last_reg <= point.last_point;
                    room_reg <= (count_reg < CNT_MAX);
                end
            end
            S_L_SQY, S_N_SQB:
            begin
                tmp_reg <= mul_q_reg;
            end
            S_C_START:
            begin
                acc_t_reg   <= '0;
                rem_len_reg <= '0;
                acc_p_reg   <= '0;
                kmax_reg    <= '0;
            end
            S_C_GETCUR:
            begin
                cx_reg <= st_rd_x;
                cy_reg <= st_rd_y;
            end
            S_C_GETNXT:
            begin
                nx_reg  <= st_rd_x;
                ny_reg  <= st_rd_y;
                bcx_reg <= sext(st_rd_x) - sext(cx_reg);
                bcy_reg <= sext(st_rd_y) - sext(cy_reg);
                ua_reg  <= abs_diff(sext(st_rd_x) - sext(cx_reg));
                ub_reg  <= abs_diff(sext(st_rd_y) - sext(cy_reg));
            end
            S_C_SEG:
            begin
                d_bc_reg    <= sq_root;
                rem_len_reg <= sat_add(rem_len_reg, sq_root);
                if (!found_reg)
                begin
                    acc_t_reg <= acc_t_sum;
                    tx_reg    <= nx_reg;
                    ty_reg    <= ny_reg;
                end
                if (pv_on_reg)
                begin
                    acc_p_reg <= acc_p_sum;
                end
                // chord from the point before the current one
                ua_reg <= abs_diff(sext(nx_reg) - sext(px_reg));
                ub_reg <= abs_diff(sext(ny_reg) - sext(py_reg));
            end
            S_C_AC:
            begin
                ac_reg <= sq_root;
            end
            S_D_M2:
            begin
                t_hi_reg <= mul_q_reg[PROD_W-1:MAG_W];
            end
            S_D_M3:
            begin
                lp_reg <= mul_q_reg;
            end
            S_D_M4:
            begin
                den_reg <= den_c;
            end
            S_X_M2:
            begin
                p_reg <= mul_q_reg;
            end
            S_X_WAIT:
            begin
                if (dv_done && (dv_quo > kmax_reg))
                begin
                    kmax_reg <= dv_quo;
                end
            end
            S_C_ADV:
            begin
                px_reg   <= cx_reg;
                py_reg   <= cy_reg;
                cx_reg   <= nx_reg;
                cy_reg   <= ny_reg;
                abx_reg  <= bcx_reg;
                aby_reg  <= bcy_reg;
                d_ab_reg <= d_bc_reg;
            end
            S_C_FINAL:
            begin
                // target is the point that reached the lookahead; if none did, fall back to the last one
                tx_reg <= sel_x;
                ty_reg <= sel_y;
                ua_reg <= abs_diff(sext(sel_x));
                ub_reg <= abs_diff(sext(sel_y));
            end
            S_C_LD:
            begin
                ld_reg <= sq_root[MAG_W-1] ? '1 : sq_root[DIST_W-1:0];
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    r_tv_reg   <= tv_reg;
                    r_near_reg <= tv_reg ? NEAR_W'(near_reg) : '0;
                    r_tx_reg   <= tv_reg ? tx_reg : '0;
                    r_ty_reg   <= tv_reg ? ty_reg : '0;
                    r_ld_reg   <= tv_reg ? ld_reg : '0;
                    r_rem_reg  <= tv_reg ? rem_len_reg : '0;
                    r_kmax_reg <= tv_reg ? kmax_reg : '0;
                    r_drop_reg <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid            = res_valid_reg;
    assign result.target_valid     = r_tv_reg;
    assign result.nearest_index    = r_near_reg;
    assign result.target_x         = r_tx_reg;
    assign result.target_y         = r_ty_reg;
    assign result.lookahead_used   = r_ld_reg;
    assign result.remaining_length = r_rem_reg;
    assign result.max_curvature    = r_kmax_reg;
    assign result.points_dropped   = r_drop_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("point count past store depth");

    a_near_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(near_reg) < count_reg))
        else $error("nearest index outside loaded points");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_N_WAIT))
        else $error("square root finished with no one waiting");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        dv_done |-> (state_reg == S_X_WAIT))
        else $error("divide finished with no one waiting");

    a_path_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((count_reg == '0) && res_valid_reg && !ovf_reg))
        else $error("path state not cleared after result");
`endif

endmodule

// ===== dv/tb_pursuit_path_query_engine.sv =====
module tb_pursuit_path_query_engine;
    import ppq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index that no register answers to; the block must ignore the write.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);
    localparam int STORE_DEPTH = MAX_POINTS_DEF;
    localparam logic [DEN_W-1:0] FLAT_LIMIT = DEGEN_LIMIT;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } point_t;

    typedef struct {
        logic               target_valid;
        logic [NEAR_W-1:0]  nearest_index;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [DIST_W-1:0]  lookahead_used;
        logic [DIST_W-1:0]  remaining_length;
        logic [DIST_W-1:0]  max_curvature;
        logic               points_dropped;
    } query_t;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ppq_point_if  point ();
    ppq_result_if result ();

    pursuit_path_query_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point.sink),
        .result    (result.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Path predictor: its own copy of the point store and search state.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] path_x[$];
    logic [COORD_W-1:0] path_y[$];
    logic [D2_W-1:0]    best_d2 = '1;
    int unsigned        best_idx = 0;
    logic               store_overflow = 1'b0;
    logic [DIST_W-1:0]  la_setting = LOOKAHEAD_RESET;
    logic [DIST_W-1:0]  preview_dist = PREVIEW_RESET;

    query_t expected_queries[$];
    int     errors = 0;

    // floor(sqrt(v)) for v below 2^66, as the block's bit-serial root
    function automatic logic [33:0] int_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] cand;
        r = 0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = r | (128'd1 << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r[33:0];
    endfunction

    function automatic logic [33:0] vec_len(input logic signed [127:0] dx,
                                            input logic signed [127:0] dy);
        return int_sqrt(dx * dx + dy * dy);
    endfunction

    function automatic logic signed [127:0] coord(input logic [COORD_W-1:0] v);
        logic signed [127:0] w;
        w = {{96{v[COORD_W-1]}}, v};
        return w;
    endfunction

    function automatic logic [33:0] span(input int unsigned i, input int unsigned j);
        return vec_len(coord(path_x[j]) - coord(path_x[i]), coord(path_y[j]) - coord(path_y[i]));
    endfunction

    function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] acc,
                                                  input logic [33:0] d);
        logic [35:0] s;
        s = acc + d;
        return (s > 36'hFFFF_FFFF) ? '1 : s[DIST_W-1:0];
    endfunction

    // Menger curvature of triple (a, a+1, a+2); flat triples give 0 and are skipped
    function automatic logic [DIST_W-1:0] bend(input int unsigned a, output logic flat);
        logic signed [127:0] abx, aby, bcx, bcy, xprod;
        logic [127:0] den, quo, mag;
        abx = coord(path_x[a+1]) - coord(path_x[a]);
        aby = coord(path_y[a+1]) - coord(path_y[a]);
        bcx = coord(path_x[a+2]) - coord(path_x[a+1]);
        bcy = coord(path_y[a+2]) - coord(path_y[a+1]);
        den = 128'(span(a, a+1)) * 128'(span(a+1, a+2)) * 128'(span(a, a+2));
        flat = (den < 128'(FLAT_LIMIT));
        if (flat)
            return '0;
        xprod = abx * bcy - aby * bcx;
        mag = (xprod < 0) ? -xprod : xprod;
        quo = (mag << 33) / den;
        return (quo > 128'hFFFF_FFFF) ? '1 : quo[DIST_W-1:0];
    endfunction

    function automatic query_t predict_query();
        query_t q;
        int unsigned n, nr, tsel, fin;
        logic [DIST_W-1:0] acc, rem, k, kmax;
        logic flat;
        q = '{default: '0};
        q.points_dropped = store_overflow;
        n = path_x.size();
        nr = best_idx;
        if (n >= 2)
        begin
            tsel = n - 1;
            acc = 0;
            for (int unsigned i = nr; i + 1 < n; i++)
            begin
                acc = add_sat(acc, span(i, i + 1));
                if (acc >= la_setting)
                begin
                    tsel = i + 1;
                    break;
                end
            end
            rem = 0;
            for (int unsigned i = nr + 1; i < n; i++)
                rem = add_sat(rem, span(i - 1, i));
            kmax = 0;
            if (nr + 2 < n)
            begin
                // walk the preview window, then scan triples that lie inside it
                fin = nr;
                acc = 0;
                while (fin + 1 < n && acc < preview_dist)
                begin
                    acc = add_sat(acc, span(fin, fin + 1));
                    fin++;
                end
                for (int unsigned i = nr; i + 2 <= fin; i++)
                begin
                    k = bend(i, flat);
                    if (!flat && k > kmax)
                        kmax = k;
                end
            end
            q.target_valid = 1'b1;
            q.nearest_index = nr[NEAR_W-1:0];
            q.target_x = path_x[tsel];
            q.target_y = path_y[tsel];
            k = '1;
            q.lookahead_used = (vec_len(coord(path_x[tsel]), coord(path_y[tsel])) > 34'(k))
                             ? k : vec_len(coord(path_x[tsel]), coord(path_y[tsel]));
            q.remaining_length = rem;
            q.max_curvature = kmax;
        end
        return q;
    endfunction

    function automatic void take_point(input point_t p);
        logic signed [63:0] sx, sy;
        logic [D2_W-1:0] d2;
        if (path_x.size() < STORE_DEPTH)
        begin
            sx = {{32{p.x[COORD_W-1]}}, p.x};
            sy = {{32{p.y[COORD_W-1]}}, p.y};
            d2 = sx * sx + sy * sy;
            if (d2 < best_d2)
            begin
                best_d2 = d2;
                best_idx = path_x.size();
            end
            path_x.push_back(p.x);
            path_y.push_back(p.y);
        end
        else
        begin
            store_overflow = 1'b1;
        end
        if (p.last)
        begin
            expected_queries.push_back(predict_query());
            path_x.delete();
            path_y.delete();
            best_d2 = '1;
            best_idx = 0;
            store_overflow = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Point driver: pulls from pending_points, random gap before each item,
    // with bursts where the gap is forced to zero.
    // ------------------------------------------------------------------
    point_t pending_points[$];
    point_t cur_point;
    logic   drv_busy = 1'b0;
    int     drv_gap = 0;
    int     drv_burst = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.valid <= 1'b0;
            point.point_x <= '0;
            point.point_y <= '0;
            point.last_point <= 1'b0;
            drv_busy = 1'b0;
        end
        else
        begin
            if (drv_busy && point.ready)
            begin
                take_point(cur_point);
                drv_busy = 1'b0;
                if (drv_burst > 0)
                    drv_burst--;
                else if ($urandom_range(0, 30) == 0)
                    drv_burst = $urandom_range(10, 60);
                drv_gap = (drv_burst > 0) ? 0 : $urandom_range(0, 11);
            end
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_points.size() > 0)
                begin
                    cur_point = pending_points.pop_front();
                    drv_busy = 1'b1;
                end
            end
            point.valid <= drv_busy;
            point.point_x <= cur_point.x;
            point.point_y <= cur_point.y;
            point.last_point <= cur_point.last;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall before each transfer, checks every field.
    // ------------------------------------------------------------------
    int mon_stall = 0;
    int mon_burst = 0;

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        query_t e;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            mon_stall = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_queries.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_queries.pop_front();
                    check_field("target_valid", e.target_valid, result.target_valid);
                    check_field("nearest_index", e.nearest_index, result.nearest_index);
                    check_field("target_x", e.target_x, result.target_x);
                    check_field("target_y", e.target_y, result.target_y);
                    check_field("lookahead_used", e.lookahead_used, result.lookahead_used);
                    check_field("remaining_length", e.remaining_length,
                                result.remaining_length);
                    check_field("max_curvature", e.max_curvature, result.max_curvature);
                    check_field("points_dropped", e.points_dropped, result.points_dropped);
                end
                if (mon_burst > 0)
                    mon_burst--;
                else if ($urandom_range(0, 8) == 0)
                    mon_burst = $urandom_range(3, 12);
                mon_stall = (mon_burst > 0) ? 0 : $urandom_range(0, 11);
            end
            if (mon_stall > 0)
            begin
                mon_stall--;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_point(input logic [31:0] x, input logic [31:0] y,
                                      input logic last);
        point_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        pending_points.push_back(p);
    endfunction

    // Smooth path starting behind or beside the vehicle; occasional repeated points
    function automatic void add_walk(input int n, input int max_step);
        real x, y, hdg, turn, stp;
        x = -$itor($urandom_range(0, 10 * 65536));
        y = $itor($urandom_range(0, 8 * 65536)) - 4.0 * 65536.0;
        hdg = ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0;
        turn = ($itor($urandom_range(0, 400)) - 200.0) / 1000.0;
        for (int i = 0; i < n; i++)
        begin
            add_point(32'($rtoi(x)), 32'($rtoi(y)), i == n - 1);
            if ($urandom_range(0, 15) == 0)
                stp = 0.0;
            else if ($urandom_range(0, 15) == 0)
                stp = $itor($urandom_range(0, 4));
            else
                stp = $itor($urandom_range(2000, max_step));
            if ($urandom_range(0, 5) == 0)
                turn = ($itor($urandom_range(0, 1600)) - 800.0) / 1000.0;
            hdg = hdg + turn;
            x = x + stp * $cos(hdg);
            y = y + stp * $sin(hdg);
        end
    endfunction

    function automatic void add_wild(input int n);
        for (int i = 0; i < n; i++)
            add_point($urandom, $urandom, i == n - 1);
    endfunction

    task automatic settle();
        while (pending_points.size() > 0 || drv_busy || expected_queries.size() > 0)
            @(posedge clk);
        // block is idle once the last result has been taken; short margin is enough
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_LOOKAHEAD)
            la_setting = val;
        else if (idx == CFG_PREVIEW)
            preview_dist = val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_paths(input int items);
        int sent, n, r;
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                n = 1;
                add_point($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 65535)),
                          $urandom, 1'b1);
            end
            else if (r < 22)
            begin
                n = $urandom_range(2, 10);
                add_wild(n);
            end
            else
            begin
                n = $urandom_range(2, 24);
                add_walk(n, $urandom_range(0, 1) ? 140000 : 30000);
            end
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point.valid = 1'b0;
        point.point_x = '0;
        point.point_y = '0;
        point.last_point = 1'b0;
        result.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset configuration: lone point, coordinate extremes,
        // repeated points (flat triples), collinear run, ordinary bend.
        add_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        add_point(32'h0001_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0001_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0001_0000, 32'h0000_0000, 1'b1);
        add_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0002_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0004_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0006_0000, 32'h0000_0000, 1'b1);
        add_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        add_point(32'h0000_0001, 32'h0000_0000, 1'b0);
        add_point(32'h0000_0001, 32'h0000_0001, 1'b1);
        add_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_walk(7, 90000);
        settle();

        // Zero lookahead, widest preview; the nearest point last in the path
        write_reg(CFG_LOOKAHEAD, 32'h0000_0000);
        write_reg(CFG_PREVIEW, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, $urandom);
        add_point(32'h0005_0000, 32'h0000_0000, 1'b0);
        add_point(32'h0003_0000, 32'h0001_0000, 1'b0);
        add_point(32'h0000_8000, 32'h0000_0000, 1'b1);
        add_walk(8, 90000);
        settle();

        // Store overflow: full store, extra points dropped, then the next path clean
        write_reg(CFG_LOOKAHEAD, 32'hFFFF_FFFF);
        write_reg(CFG_PREVIEW, 32'h0000_0000);
        add_walk(STORE_DEPTH + 3, 30000);
        add_walk(3, 60000);
        settle();
        write_reg(CFG_PREVIEW, 32'hFFFF_FFFF);
        add_walk(STORE_DEPTH + 1, 20000);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_LOOKAHEAD, LOOKAHEAD_RESET);
                    write_reg(CFG_PREVIEW, PREVIEW_RESET);
                end
                1:
                begin
                    write_reg(CFG_LOOKAHEAD, 32'h0000_0000);
                    write_reg(CFG_PREVIEW, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_reg(CFG_LOOKAHEAD, 32'hFFFF_FFFF);
                    write_reg(CFG_PREVIEW, 32'h0000_0000);
                end
                3:
                begin
                    write_reg(CFG_LOOKAHEAD, $urandom);
                    write_reg(CFG_PREVIEW, $urandom);
                end
                default:
                begin
                    write_reg(CFG_LOOKAHEAD, $urandom_range(0, 20 * 65536));
                    write_reg(CFG_PREVIEW, $urandom_range(0, 30 * 65536));
                end
            endcase
            random_paths(200);
            settle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
